@@ hw/rtl/morse_element_sequencer_core_defines.svh @@
// Assertion macros used by the checker of the Morse keyer.
`ifndef MORSE_ELEMENT_SEQUENCER_CORE_DEFINES_SVH
`define MORSE_ELEMENT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define MES_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define MES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mes_pkg.sv @@
// Shared types, constants and helper functions of the Morse keyer.
`default_nettype none

package mes_pkg;

    localparam int CODE_W      = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int RES_W       = 5;
    localparam int OUT_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_CODE = 1'd1;

    localparam logic [CODE_W-1:0] END_CODE_RESET = 8'hFF;
    localparam logic [1:0]        DAH_UNITS      = 2'd3;
    localparam logic [1:0]        LETTER_UNITS   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DIT    = 3'd1,
        PH_DAH    = 3'd2,
        PH_GAP    = 3'd3,
        PH_LETTER = 3'd4,
        PH_SPACE  = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [CODE_W-1:0]   bit_mask;
        logic [CODE_W-1:0]   held_code;
        logic [1:0]          unit_count;
        logic                tone;
    } keyer_state_t;

    typedef struct packed {
        logic restart_unit_timer;
        logic msg_end;
        logic idle;
        logic char_taken;
        logic tone_on;
    } keyer_result_t;

    localparam keyer_state_t STATE_CLEAR = '{
        phase:      PH_IDLE,
        bit_mask:   '0,
        held_code:  '0,
        unit_count: '0,
        tone:       1'b0
    };

    // Returns the single bit of the first zero below the leading ones,
    // or zero when the code is all ones.
    function automatic logic [CODE_W-1:0] marker_end(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] mask;
        logic              found;
        mask  = '0;
        found = 1'b0;
        for (int i = CODE_W - 1; i >= 0; i--) begin
            if (!found && !code[i]) begin
                mask[i] = 1'b1;
                found   = 1'b1;
            end
        end
        return mask;
    endfunction

    // Steps to the element selected by mask; an empty mask enters the letter gap.
    function automatic keyer_state_t enter_element(input keyer_state_t s,
                                                   input logic [CODE_W-1:0] mask);
        keyer_state_t n;
        n            = s;
        n.unit_count = '0;
        n.bit_mask   = mask;
        if (mask == '0) begin
            n.held_code = '0;
            n.tone      = 1'b0;
            n.phase     = PH_LETTER;
        end
        else begin
            n.tone  = 1'b1;
            n.phase = ((mask & s.held_code) != '0) ? PH_DAH : PH_DIT;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/morse_element_sequencer_core.sv @@
// Top level of the Morse keyer: input register, state update and result register.
`default_nettype none

// The keyer takes one transfer per cycle unless the output side stalls, and
// returns one result transfer for each, via the input and result registers. A
// tick transfer (tuser 0) advances the keying by one Morse unit, and a code
// transfer (tuser 1) offers a character that is taken only while idle. Each
// item passes an input register, one step of next-state logic and a result
// register; the keyer state updates as the item moves into the result
// register, so throughput is limited only by the output handshake. The
// enable register must be written while no item is in flight; any write to it
// aborts the current character.
module morse_element_sequencer_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mes_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mes_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // char_code[7:0].
    input  wire logic [mes_pkg::CODE_W-1:0]         s_tdata,
    // func.
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tone_on, char_taken, idle, msg_end, restart_unit_timer, zero padding.
    output logic [mes_pkg::OUT_DATA_W-1:0]          m_tdata
);

    logic                          enable_reg;
    logic [mes_pkg::CODE_W-1:0]    end_code_reg;
    mes_pkg::keyer_state_t         state_reg;
    mes_pkg::keyer_state_t         state_next;
    mes_pkg::keyer_result_t        result_next;
    mes_pkg::keyer_result_t        result_reg;
    logic                          in_valid_reg;
    logic                          in_func_reg;
    logic [mes_pkg::CODE_W-1:0]    in_code_reg;
    logic                          out_valid_reg;
    logic                          advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    mes_step u_step (
        .enable    (enable_reg),
        .end_code  (end_code_reg),
        .cur       (state_reg),
        .func      (in_func_reg),
        .char_code (in_code_reg),
        .nxt       (state_next),
        .res       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg    <= 1'b0;
            end_code_reg  <= mes_pkg::END_CODE_RESET;
            state_reg     <= mes_pkg::STATE_CLEAR;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_we && cfg_index == mes_pkg::CFG_ENABLE) begin
                enable_reg <= cfg_wdata[0];
                state_reg  <= mes_pkg::STATE_CLEAR;
            end
            else if (advance && in_valid_reg) begin
                state_reg <= state_next;
            end
            if (cfg_we && cfg_index == mes_pkg::CFG_END_CODE) begin
                end_code_reg <= cfg_wdata[mes_pkg::CODE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_code_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mes_pkg::OUT_DATA_W - mes_pkg::RES_W){1'b0}}, result_reg};

endmodule

`default_nettype wire

@@ hw/rtl/mes_step.sv @@
// Next-state and result logic of the keyer for one transfer.
`default_nettype none

module mes_step (
    input  wire logic                          enable,
    input  wire logic [mes_pkg::CODE_W-1:0]    end_code,
    input  wire mes_pkg::keyer_state_t         cur,
    input  wire logic                          func,
    input  wire logic [mes_pkg::CODE_W-1:0]    char_code,
    output mes_pkg::keyer_state_t              nxt,
    output mes_pkg::keyer_result_t             res
);

    logic [1:0] unit_inc;
    mes_pkg::keyer_state_t loaded;

    assign unit_inc = cur.unit_count + 2'd1;

    always_comb
    begin
        loaded           = cur;
        loaded.held_code = char_code;
        nxt              = cur;
        if (enable)
        begin
            if (func)
            begin
                if (cur.phase == mes_pkg::PH_IDLE && char_code != end_code &&
                    char_code != '0)
                begin
                    if (!char_code[mes_pkg::CODE_W-1])
                    begin
                        nxt.held_code = char_code;
                        nxt.phase     = mes_pkg::PH_SPACE;
                    end
                    else
                    begin
                        nxt = mes_pkg::enter_element(loaded,
                                  mes_pkg::marker_end(char_code) >> 1);
                    end
                end
            end
            else
            begin
                unique case (cur.phase)
                    mes_pkg::PH_DIT:
                    begin
                        nxt.tone  = 1'b0;
                        nxt.phase = mes_pkg::PH_GAP;
                    end
                    mes_pkg::PH_DAH:
                    begin
                        nxt.unit_count = unit_inc;
                        if (unit_inc >= mes_pkg::DAH_UNITS)
                        begin
                            nxt.tone  = 1'b0;
                            nxt.phase = mes_pkg::PH_GAP;
                        end
                    end
                    mes_pkg::PH_GAP:
                    begin
                        nxt = mes_pkg::enter_element(cur, cur.bit_mask >> 1);
                    end
                    mes_pkg::PH_LETTER:
                    begin
                        nxt.unit_count = unit_inc;
                        if (unit_inc >= mes_pkg::LETTER_UNITS)
                        begin
                            nxt.phase = mes_pkg::PH_IDLE;
                        end
                    end
                    mes_pkg::PH_SPACE:
                    begin
                        if (cur.held_code == '0)
                        begin
                            nxt.phase = mes_pkg::PH_IDLE;
                        end
                        else
                        begin
                            nxt.held_code = cur.held_code - 8'd1;
                        end
                    end
                    default:
                    begin
                        nxt = cur;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res = '0;
        if (enable)
        begin
            if (func && cur.phase == mes_pkg::PH_IDLE)
            begin
                if (char_code == end_code)
                begin
                    res.char_taken = 1'b1;
                    res.msg_end    = 1'b1;
                end
                else if (char_code != '0)
                begin
                    res.char_taken         = 1'b1;
                    res.restart_unit_timer = char_code[mes_pkg::CODE_W-1];
                end
            end
            res.tone_on = nxt.tone;
            res.idle    = (nxt.phase == mes_pkg::PH_IDLE);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mes_checker.sv @@
// Port-level checker of the Morse keyer and its bind to the top level.
`default_nettype none
`include "morse_element_sequencer_core_defines.svh"

module mes_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tready,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [mes_pkg::OUT_DATA_W-1:0]     m_tdata
);

    `MES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `MES_ASSERT_SAME(a_ready_backpressure, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")
    `MES_ASSERT_SAME(a_reset_empty, !$past(rst_n), !m_tvalid, "result transfer offered right after reset")
    `MES_ASSERT_SAME(a_msg_end_shape, m_tvalid && m_tdata[3], m_tdata[1] && m_tdata[2] && !m_tdata[0] && !m_tdata[4], "end code result is inconsistent")
    `MES_ASSERT_SAME(a_tone_not_idle, m_tvalid && m_tdata[0], !m_tdata[2], "tone keyed while reported idle")

endmodule

bind morse_element_sequencer_core mes_checker u_mes_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/morse_element_sequencer_core_tb.sv @@
// Self-checking testbench of the Morse keyer core with driver, monitor and predictor.
`timescale 1ns / 100ps

module morse_element_sequencer_core_tb;

    import mes_pkg::*;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CODE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
    } keyer_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CODE_W-1:0]      s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    keyer_item_t   pending_items[$];
    keyer_result_t expected_results[$];
    int            queued_count = 0;
    int            accepted_count = 0;
    int            results_seen = 0;
    int            error_count = 0;
    int            backpressure_left = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    logic              run_enable = 1'b0;
    logic [CODE_W-1:0] end_marker = END_CODE_RESET;
    phase_t            cur_phase = PH_IDLE;
    logic [CODE_W-1:0] elem_mask = '0;
    logic [CODE_W-1:0] code_reg = '0;
    logic [1:0]        units = '0;
    logic              tone_now = 1'b0;

    morse_element_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic void clear_keying();
        cur_phase = PH_IDLE;
        elem_mask = '0;
        code_reg  = '0;
        units     = '0;
        tone_now  = 1'b0;
    endfunction

    function automatic void advance_element();
        units     = '0;
        elem_mask = elem_mask >> 1;
        if (elem_mask == '0)
        begin
            code_reg  = '0;
            tone_now  = 1'b0;
            cur_phase = PH_LETTER;
        end
        else
        begin
            tone_now  = 1'b1;
            cur_phase = ((elem_mask & code_reg) != '0) ? PH_DAH : PH_DIT;
        end
    endfunction

    function automatic keyer_result_t predict_result(input logic func,
                                                     input logic [CODE_W-1:0] code);
        keyer_result_t     res;
        logic [CODE_W-1:0] m;
        res = '0;
        if (!run_enable)
            return res;
        if (func == FUNC_CODE)
        begin
            if (cur_phase == PH_IDLE)
            begin
                if (code == end_marker)
                begin
                    res.char_taken = 1'b1;
                    res.msg_end    = 1'b1;
                end
                else if (code != '0)
                begin
                    res.char_taken = 1'b1;
                    code_reg       = code;
                    if (!code[CODE_W-1])
                        cur_phase = PH_SPACE;
                    else
                    begin
                        m = 8'h80;
                        while ((m & code) != '0)
                            m = m >> 1;
                        elem_mask              = m;
                        res.restart_unit_timer = 1'b1;
                        advance_element();
                    end
                end
            end
        end
        else
        begin
            case (cur_phase)
                PH_DIT:
                begin
                    tone_now  = 1'b0;
                    cur_phase = PH_GAP;
                end
                PH_DAH:
                begin
                    units = units + 2'd1;
                    if (units >= DAH_UNITS)
                    begin
                        tone_now  = 1'b0;
                        cur_phase = PH_GAP;
                    end
                end
                PH_GAP:
                    advance_element();
                PH_LETTER:
                begin
                    units = units + 2'd1;
                    if (units >= LETTER_UNITS)
                        cur_phase = PH_IDLE;
                end
                PH_SPACE:
                begin
                    if (code_reg == '0)
                        cur_phase = PH_IDLE;
                    else
                        code_reg = code_reg - 8'd1;
                end
                default:
                    ;
            endcase
        end
        res.tone_on = tone_now;
        res.idle    = (cur_phase == PH_IDLE);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 200)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_item(input logic func, input logic [CODE_W-1:0] code);
        keyer_item_t it;
        it.func = func;
        it.code = code;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_ENABLE)
        begin
            run_enable = value[0];
            clear_keying();
        end
        else
            end_marker = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly complete characters and spaces followed by enough ticks to finish them,
    // with offers while busy, end codes and arbitrary items mixed in.
    task automatic queue_random_traffic(input int n);
        int                added;
        int                kind;
        int                k;
        int                dur;
        int                extra;
        logic [CODE_W-1:0] c;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                if (kind < 45)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        c   = 8'hFF;
                        dur = 2;
                    end
                    else
                    begin
                        k   = $urandom_range(0, 6);
                        dur = 2;
                        for (int i = 0; i < CODE_W; i++)
                        begin
                            if (i > k)
                                c[i] = 1'b1;
                            else if (i == k)
                                c[i] = 1'b0;
                            else
                            begin
                                c[i] = 1'($urandom_range(0, 1));
                                dur  = dur + (c[i] ? 4 : 2);
                            end
                        end
                    end
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        c = CODE_W'($urandom_range(1, 127));
                    else
                        c = CODE_W'($urandom_range(1, 7));
                    dur = c + 1;
                end
                add_item(FUNC_CODE, c);
                added++;
                extra = dur + $urandom_range(0, 2);
                for (int j = 0; j < extra; j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        add_item(FUNC_CODE, CODE_W'($urandom_range(0, 255)));
                    else
                        add_item(FUNC_TICK, CODE_W'($urandom_range(0, 255)));
                    added++;
                end
            end
            else if (kind < 80)
            begin
                add_item(FUNC_CODE, end_marker);
                added++;
            end
            else if (kind < 90)
            begin
                add_item(FUNC_CODE, CODE_W'($urandom_range(0, 255)));
                added++;
                extra = $urandom_range(0, 3);
                for (int j = 0; j < extra; j++)
                begin
                    add_item(FUNC_TICK, CODE_W'($urandom_range(0, 255)));
                    added++;
                end
            end
            else
            begin
                add_item(FUNC_TICK, CODE_W'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    always @(posedge clk)
    begin : stimulus_driver
        logic        next_valid;
        keyer_item_t next_item;
        next_valid = s_tvalid;
        if (!rst_n)
            next_valid = 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(predict_result(s_tuser, s_tdata));
                accepted_count++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_items.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_item = pending_items.pop_front();
                s_tuser   <= next_item.func;
                s_tdata   <= next_item.code;
                next_valid = 1'b1;
            end
        end
        s_tvalid <= next_valid;
    end

    always @(posedge clk)
    begin : result_monitor
        keyer_result_t got;
        keyer_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[RES_W-1:0];
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result transfer with nothing expected: %b",
                                              m_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.tone_on !== want.tone_on ||
                        got.char_taken !== want.char_taken ||
                        got.idle !== want.idle ||
                        got.msg_end !== want.msg_end ||
                        got.restart_unit_timer !== want.restart_unit_timer ||
                        m_tdata[OUT_DATA_W-1:RES_W] !== '0)
                        report_mismatch($sformatf(
                    "result %0d: tone %b/%b taken %b/%b idle %b/%b end %b/%b rst %b/%b pad %b",
                            results_seen, got.tone_on, want.tone_on,
                            got.char_taken, want.char_taken, got.idle, want.idle,
                            got.msg_end, want.msg_end, got.restart_unit_timer,
                            want.restart_unit_timer, m_tdata[OUT_DATA_W-1:RES_W]));
                end
                if (results_seen % 300 == 150)
                    backpressure_left = 80;
            end
            if (backpressure_left > 0)
            begin
                backpressure_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("morse_element_sequencer_core test failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n         <= 1'b1;
        send_idle_pct <= 28;
        recv_idle_pct <= 49;

        // Disabled after reset: everything is ignored.
        @(negedge clk);
        add_item(FUNC_CODE, 8'h85);
        add_item(FUNC_TICK, 8'hFF);
        wait_drained();

        write_register(CFG_END_CODE, 8'hFF);
        write_register(CFG_ENABLE, 8'h01);
        @(negedge clk);
        add_item(FUNC_CODE, 8'hFF);
        add_item(FUNC_CODE, 8'h00);
        add_item(FUNC_TICK, 8'h00);
        // A single dah, with an offer while it is keyed.
        add_item(FUNC_CODE, 8'hFD);
        add_item(FUNC_CODE, 8'h80);
        repeat (6) add_item(FUNC_TICK, 8'hFF);
        // Marker only, no elements.
        add_item(FUNC_CODE, 8'hFE);
        repeat (2) add_item(FUNC_TICK, 8'h00);
        // Word space of two units.
        add_item(FUNC_CODE, 8'h01);
        repeat (2) add_item(FUNC_TICK, 8'hFF);
        // A single dit.
        add_item(FUNC_CODE, 8'hFC);
        repeat (3) add_item(FUNC_TICK, 8'h00);
        wait_drained();

        // The end code check comes before the zero check.
        write_register(CFG_END_CODE, 8'h00);
        @(negedge clk);
        add_item(FUNC_CODE, 8'h00);
        wait_drained();

        write_register(CFG_END_CODE, CFG_DATA_W'($urandom_range(1, 254)));
        @(negedge clk);
        queue_random_traffic(160);
        wait_drained();
        @(negedge clk);
        queue_random_traffic(160);
        wait_drained();

        send_idle_pct <= 49;
        recv_idle_pct <= 28;
        write_register(CFG_END_CODE, 8'h00);
        @(negedge clk);
        queue_random_traffic(320);
        wait_drained();

        write_register(CFG_ENABLE, 8'h00);
        @(negedge clk);
        queue_random_traffic(20);
        wait_drained();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_register(CFG_ENABLE, 8'h01);
        write_register(CFG_END_CODE, 8'hFF);
        @(negedge clk);
        queue_random_traffic(310);
        wait_drained();

        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("morse_element_sequencer_core test passed");
        else
            $display("morse_element_sequencer_core test failed");
        $finish;
    end

endmodule
